[rtl/ioc_pkg.sv]
// ----------------------------------------------------------------------------
// ioc_pkg
// Shared constants, field widths, result codes and the ones-count helper
// used by the incremental order checker.
// ----------------------------------------------------------------------------
package ioc_pkg;

    localparam int MAX_NODES_DEF  = 26;
    localparam int NODE_W         = 5;
    localparam int CNT_W          = 10;
    localparam int STATUS_W       = 3;
    localparam int CFG_W          = 5;
    localparam int NODE_COUNT_RST = 26;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 16;

    typedef enum logic [STATUS_W-1:0] {
        STAT_PENDING      = 3'd0,
        STAT_INCONSISTENT = 3'd1,
        STAT_SORTED       = 3'd2,
        STAT_UNDETERMINED = 3'd3,
        STAT_IGNORED      = 3'd4
    } status_t;

    // adder tree over a 32-bit word
    function automatic logic [5:0] ones_count(input logic [31:0] v);
        logic [1:0] l1 [16];
        logic [2:0] l2 [8];
        logic [3:0] l3 [4];
        logic [4:0] l4 [2];
        for (int i = 0; i < 16; i++)
        begin
            l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        end
        return {1'b0, l4[0]} + {1'b0, l4[1]};
    endfunction

endpackage

[rtl/ioc_reach_ram.sv]
// ----------------------------------------------------------------------------
// ioc_reach_ram
// Reachability row store: one row per letter, synchronous read with registered
// output, per-row valid bits so a new case clears the whole store at once.
// ----------------------------------------------------------------------------
module ioc_reach_ram #(
    parameter int MAX_NODES = ioc_pkg::MAX_NODES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
    output logic [MAX_NODES-1:0]         rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
    input  logic [MAX_NODES-1:0]         wr_data
);

    logic [MAX_NODES-1:0] reach_mem [MAX_NODES];
    logic [MAX_NODES-1:0] row_valid_reg;
    logic [MAX_NODES-1:0] mem_q_reg;
    logic                 valid_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (clear)
        begin
            row_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            row_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            reach_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg   <= reach_mem[rd_addr];
            valid_q_reg <= row_valid_reg[rd_addr];
        end
    end

    assign rd_data = valid_q_reg ? mem_q_reg : '0;

    a_no_clear_during_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(clear && wr_en))
        else $error("row store cleared while a row is written");

endmodule

[rtl/incremental_order_checker_unit.sv]
// ----------------------------------------------------------------------------
// incremental_order_checker_unit
// Incremental order checker: keeps the transitive closure of "smaller before
// larger" relations and reports inconsistent, sorted, pending, undetermined or ignored per relation.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one relation per transaction: tdata holds smaller_node and
//   larger_node, tuser is case_start, tlast is case_end. cfg_* writes
//   node_count (always ready); write it only while the block is idle.
//   m_axis returns results: tuser is the status code, tdata holds
//   relation_number and order_letter, tlast marks the final result of a
//   relation. A sorted outcome gives n results (one per letter), first letter first;
//   every other outcome gives one result.
// Sequence (n = effective node count):
//   An ignored relation (case already decided) goes from acceptance straight
//   to the emit state. Otherwise the row of larger_node is loaded, the n
//   rows are swept, the sweep pipeline drains, the outcome is decided and
//   the output register is loaded; sorted results follow one per cycle while
//   the receiver is ready. s_axis_tready is high only when the previous
//   relation's results are all handed to the output register, so a new
//   relation is not taken before the last one is through.
// Reset clears the store, counters and decision flag; node_count becomes 26.
// A stalled receiver holds the output register and stops the result walk.
// ----------------------------------------------------------------------------
module incremental_order_checker_unit #(
    parameter int MAX_NODES = ioc_pkg::MAX_NODES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ioc_pkg::CFG_W-1:0]       cfg_data,      // node_count
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ioc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // smaller_node, larger_node
    input  logic                            s_axis_tuser,  // case_start
    input  logic                            s_axis_tlast,  // case_end
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ioc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // relation_number, order_letter
    output logic [ioc_pkg::STATUS_W-1:0]    m_axis_tuser,  // status
    output logic                            m_axis_tlast   // last_of_run
);

    import ioc_pkg::*;

    localparam int IW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOADL,
        S_GETL,
        S_SWEEP,
        S_FLUSH,
        S_DECIDE,
        S_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     node_count_reg;
    logic [NW-1:0]        n_reg, n_next;
    logic [IW-1:0]        s_reg, s_next;
    logic [IW-1:0]        l_reg, l_next;
    logic                 upd_reg, upd_next;
    logic                 end_reg, end_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 decided_reg, decided_next;
    logic [MAX_NODES-1:0] add_reg, add_next;
    logic [NW-1:0]        iss_reg, iss_next;
    logic                 s1_valid_reg, s1_valid_next;
    logic [IW-1:0]        s1_idx_reg, s1_idx_next;
    logic                 s2_valid_reg, s2_valid_next;
    logic [MAX_NODES-1:0] s2_row_reg, s2_row_next;
    logic [IW-1:0]        s2_idx_reg, s2_idx_next;
    logic                 cyc_reg, cyc_next;
    logic [MAX_NODES-1:0] seen_reg, seen_next;
    status_t              kind_reg, kind_next;
    logic [NW-1:0]        pos_reg, pos_next;
    logic                 ovalid_reg, ovalid_next;
    status_t              ostatus_reg, ostatus_next;
    logic [CNT_W-1:0]     onum_reg, onum_next;
    logic [NODE_W-1:0]    oletter_reg, oletter_next;
    logic                 olast_reg, olast_next;

    logic [IW-1:0]        letter_at [MAX_NODES];

    logic                 accept_in;
    logic                 out_free;
    logic [NODE_W-1:0]    in_s;
    logic [NODE_W-1:0]    in_l;
    logic [NW-1:0]        n_eff;
    logic [CNT_W-1:0]     cnt_base;
    logic [MAX_NODES-1:0] mask;
    logic                 ram_rd_en;
    logic [IW-1:0]        ram_rd_addr;
    logic [MAX_NODES-1:0] ram_rd_data;
    logic                 hit;
    logic [MAX_NODES-1:0] new_row;
    logic [5:0]           pc;
    logic                 pc_ok;
    logic                 total;

    ioc_reach_ram #(
        .MAX_NODES (MAX_NODES)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (accept_in && s_axis_tuser),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_idx_reg),
        .wr_data (new_row)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept_in     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ovalid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;
    assign in_s          = s_axis_tdata[NODE_W-1:0];
    assign in_l          = s_axis_tdata[2*NODE_W-1:NODE_W];

    always_comb
    begin
        if (node_count_reg < CFG_W'(2))
        begin
            n_eff = NW'(2);
        end
        else if (6'(node_count_reg) > 6'(MAX_NODES))
        begin
            n_eff = NW'(MAX_NODES);
        end
        else
        begin
            n_eff = NW'(node_count_reg);
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_NODES; k++)
        begin
            mask[k] = (k < int'(n_reg));
        end
    end

    assign hit     = upd_reg && ((s1_idx_reg == s_reg) || ram_rd_data[s_reg]);
    assign new_row = ram_rd_data | (hit ? add_reg : '0);
    assign pc      = ones_count(32'(s2_row_reg & mask));
    assign pc_ok   = (pc < 6'(MAX_NODES));
    assign total   = &(seen_reg | ~mask);

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        s_next        = s_reg;
        l_next        = l_reg;
        upd_next      = upd_reg;
        end_next      = end_reg;
        cnt_next      = cnt_reg;
        decided_next  = decided_reg;
        add_next      = add_reg;
        iss_next      = iss_reg;
        s1_valid_next = 1'b0;
        s1_idx_next   = s1_idx_reg;
        s2_valid_next = s1_valid_reg;
        s2_row_next   = new_row;
        s2_idx_next   = s1_idx_reg;
        cyc_next      = cyc_reg;
        seen_next     = seen_reg;
        kind_next     = kind_reg;
        pos_next      = pos_reg;
        ovalid_next   = ovalid_reg && !m_axis_tready;
        ostatus_next  = ostatus_reg;
        onum_next     = onum_reg;
        oletter_next  = oletter_reg;
        olast_next    = olast_reg;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = l_reg;
        cnt_base      = s_axis_tuser ? '0 : cnt_reg;

        if (s2_valid_reg)
        begin
            cyc_next = cyc_reg || s2_row_reg[s2_idx_reg];
            if (pc_ok)
            begin
                seen_next[IW'(pc)] = 1'b1;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    n_next       = n_eff;
                    s_next       = IW'(in_s);
                    l_next       = IW'(in_l);
                    upd_next     = (6'(in_s) < 6'(n_eff)) && (6'(in_l) < 6'(n_eff));
                    end_next     = s_axis_tlast;
                    cnt_next     = (cnt_base < CNT_MAX) ? cnt_base + 1'b1 : cnt_base;
                    decided_next = decided_reg && !s_axis_tuser;
                    if (decided_reg && !s_axis_tuser)
                    begin
                        kind_next  = STAT_IGNORED;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_LOADL;
                    end
                end
            end
            S_LOADL:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = l_reg;
                state_next  = S_GETL;
            end
            S_GETL:
            begin
                add_next   = ram_rd_data | (MAX_NODES'(1) << l_reg);
                cyc_next   = 1'b0;
                seen_next  = '0;
                iss_next   = '0;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                ram_rd_en     = 1'b1;
                ram_rd_addr   = IW'(iss_reg);
                s1_valid_next = 1'b1;
                s1_idx_next   = IW'(iss_reg);
                iss_next      = iss_reg + 1'b1;
                if (iss_reg == n_reg - 1'b1)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                pos_next   = '0;
                state_next = S_EMIT;
                if (cyc_reg)
                begin
                    kind_next    = STAT_INCONSISTENT;
                    decided_next = 1'b1;
                end
                else if (total)
                begin
                    kind_next    = STAT_SORTED;
                    decided_next = 1'b1;
                end
                else
                begin
                    kind_next = end_reg ? STAT_UNDETERMINED : STAT_PENDING;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = kind_reg;
                    onum_next    = cnt_reg;
                    if (kind_reg == STAT_SORTED)
                    begin
                        oletter_next = NODE_W'(letter_at[IW'(n_reg - 1'b1 - pos_reg)]);
                        olast_next   = (pos_reg == n_reg - 1'b1);
                        pos_next     = pos_reg + 1'b1;
                        if (pos_reg == n_reg - 1'b1)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        oletter_next = '0;
                        olast_next   = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= CFG_W'(NODE_COUNT_RST);
            n_reg          <= NW'(MAX_NODES);
            s_reg          <= '0;
            l_reg          <= '0;
            upd_reg        <= 1'b0;
            end_reg        <= 1'b0;
            cnt_reg        <= '0;
            decided_reg    <= 1'b0;
            add_reg        <= '0;
            iss_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s1_idx_reg     <= '0;
            s2_valid_reg   <= 1'b0;
            s2_row_reg     <= '0;
            s2_idx_reg     <= '0;
            cyc_reg        <= 1'b0;
            seen_reg       <= '0;
            kind_reg       <= STAT_PENDING;
            pos_reg        <= '0;
            ovalid_reg     <= 1'b0;
            ostatus_reg    <= STAT_PENDING;
            onum_reg       <= '0;
            oletter_reg    <= '0;
            olast_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end
            n_reg          <= n_next;
            s_reg          <= s_next;
            l_reg          <= l_next;
            upd_reg        <= upd_next;
            end_reg        <= end_next;
            cnt_reg        <= cnt_next;
            decided_reg    <= decided_next;
            add_reg        <= add_next;
            iss_reg        <= iss_next;
            s1_valid_reg   <= s1_valid_next;
            s1_idx_reg     <= s1_idx_next;
            s2_valid_reg   <= s2_valid_next;
            s2_row_reg     <= s2_row_next;
            s2_idx_reg     <= s2_idx_next;
            cyc_reg        <= cyc_next;
            seen_reg       <= seen_next;
            kind_reg       <= kind_next;
            pos_reg        <= pos_next;
            ovalid_reg     <= ovalid_next;
            ostatus_reg    <= ostatus_next;
            onum_reg       <= onum_next;
            oletter_reg    <= oletter_next;
            olast_reg      <= olast_next;
        end
    end

    // rank table: letter with k successors lands in slot k
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && pc_ok)
        begin
            letter_at[IW'(pc)] <= s2_idx_reg;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = ostatus_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({oletter_reg, onum_reg});
    assign m_axis_tlast  = olast_reg;

    a_ready_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("input taken while the row sweep is still in flight");

    a_ignored_direct: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && decided_reg && !s_axis_tuser) |=> (state_reg == S_EMIT))
        else $error("relation of a decided case did not go straight to output");

    a_single_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != STAT_SORTED)) |-> m_axis_tlast)
        else $error("non-sorted result without last marker");

    a_number_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (onum_reg != '0))
        else $error("result carries relation number zero");

endmodule
